>>> rtl/core/jqte_pkg.sv
// ----------------------------------------------------------------------------
// jqte_pkg
// Shared types, codes and sizes of the job queue time estimator.
// ----------------------------------------------------------------------------
package jqte_pkg;

  // default sizes
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 16;

  // fixed field widths
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned OUT_ID_W = 16;
  localparam int unsigned TOTAL_W  = 40;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_DEL   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SEARCH,
    ST_SHIFT,
    ST_DEL_DONE,
    ST_SUM,
    ST_DONE
  } state_e;

  // input item
  typedef struct packed {
    logic [1:0]          action;
    logic [LEN_W-1:0]    job_length;
    logic [OUT_ID_W-1:0] target_id;
    logic [TIME_W-1:0]   now_time;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [OUT_ID_W-1:0] assigned_id;
    logic                add_refused;
    logic                delete_found;
    logic                started_valid;
    logic [OUT_ID_W-1:0] started_id;
    logic [TOTAL_W-1:0]  total_time;
    logic                queue_empty;
  } out_item_t;

endpackage

>>> rtl/core/jqte_if.sv
// ----------------------------------------------------------------------------
// jqte_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface jqte_in_if;
  logic                valid;
  logic                ready;
  jqte_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface jqte_out_if;
  logic                valid;
  logic                ready;
  jqte_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/jqte_ram.sv
// ----------------------------------------------------------------------------
// jqte_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module jqte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/job_queue_time_estimator.sv
// ----------------------------------------------------------------------------
// job_queue_time_estimator
// Ordered job queue in a RAM with add, delete by id and total time estimate.
// ----------------------------------------------------------------------------
// From accept to result: a query runs the sum pass over the queued jobs, an add
// appends at the tail first (a refused add writes nothing), a delete searches
// and, on a match, shifts and drops the entry before the sum pass. One item at a
// time: input is ready only in idle, reached when the result is registered.
// Reset clears the queue count, id counter and head state at once; the entry
// RAM is not cleared and needs no clearing pass.
module job_queue_time_estimator #(
  parameter int unsigned QUEUE_DEPTH = jqte_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = jqte_pkg::ID_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  jqte_in_if.sink    in_i,
  jqte_out_if.source out_o
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW    = jqte_pkg::LEN_W;
  localparam int unsigned RW    = ID_BITS + LW;
  localparam int unsigned OW    = jqte_pkg::OUT_ID_W;
  localparam int unsigned TW    = jqte_pkg::TOTAL_W;

  jqte_pkg::state_e state_q, state_d;

  jqte_pkg::in_item_t  item_q, item_d;
  jqte_pkg::out_item_t out_q, out_d;
  logic                out_vld_q, out_vld_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic [ID_BITS-1:0] next_id_q, next_id_d;
  logic               head_started_q, head_started_d;
  logic [LW-1:0]      head_time_q, head_time_d;
  logic [TW-1:0]      acc_q, acc_d;
  logic               refused_q, refused_d;
  logic               found_q, found_d;
  logic               started_q, started_d;
  logic [OW-1:0]      started_id_q, started_id_d;
  logic [OW-1:0]      assigned_q, assigned_d;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  jqte_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared conditions
  logic               in_acc;
  logic               out_free;
  logic               queue_nil;
  logic               queue_full;
  logic               can_issue;
  logic               last_rd;
  logic               rd_match;
  logic [ID_BITS-1:0] rd_id;
  logic [LW-1:0]      rd_len;
  logic [LW-1:0]      elapsed;
  logic [LW-1:0]      part;
  logic [TW:0]        sum_tmp;
  logic [TW-1:0]      acc_next;

  assign in_i.ready = (state_q == jqte_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign queue_nil  = (count_q == '0);
  assign queue_full = (count_q == CNT_W'(QUEUE_DEPTH));
  assign can_issue  = (idx_q < count_q);

  assign rd_id    = ram_rdata[RW-1:LW];
  assign rd_len   = ram_rdata[LW-1:0];
  assign last_rd  = rd_vld_q && (CNT_W'(rd_idx_q) == count_q - CNT_W'(1));
  assign rd_match = rd_vld_q && (OW'(rd_id) == item_q.target_id);

  // running head counts the larger of elapsed time and length
  assign elapsed  = item_q.now_time - head_time_q;
  assign part     = (head_started_q && (rd_idx_q == '0) && (elapsed >= rd_len))
                    ? elapsed : rd_len;
  assign sum_tmp  = {1'b0, acc_q} + (TW + 1)'(part);
  assign acc_next = sum_tmp[TW] ? jqte_pkg::TOTAL_MAX : sum_tmp[TW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      jqte_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_i.data.action)
            jqte_pkg::ACT_ADD: state_d = jqte_pkg::ST_ADD;
            jqte_pkg::ACT_DEL: state_d = jqte_pkg::ST_SEARCH;
            default:           state_d = jqte_pkg::ST_SUM;
          endcase
        end
      end
      jqte_pkg::ST_ADD: state_d = jqte_pkg::ST_SUM;
      jqte_pkg::ST_SEARCH: begin
        if (queue_nil) begin
          state_d = jqte_pkg::ST_SUM;
        end else if (rd_match) begin
          state_d = last_rd ? jqte_pkg::ST_DEL_DONE : jqte_pkg::ST_SHIFT;
        end else if (last_rd) begin
          state_d = jqte_pkg::ST_SUM;
        end
      end
      jqte_pkg::ST_SHIFT: begin
        if (last_rd) begin
          state_d = jqte_pkg::ST_DEL_DONE;
        end
      end
      jqte_pkg::ST_DEL_DONE: state_d = jqte_pkg::ST_SUM;
      jqte_pkg::ST_SUM: begin
        if (queue_nil || last_rd) begin
          state_d = jqte_pkg::ST_DONE;
        end
      end
      jqte_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = jqte_pkg::ST_IDLE;
        end
      end
      default: state_d = jqte_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    item_d         = item_q;
    count_d        = count_q;
    idx_d          = idx_q;
    pos_d          = pos_q;
    rd_vld_d       = 1'b0;
    rd_idx_d       = idx_q[AW-1:0];
    next_id_d      = next_id_q;
    head_started_d = head_started_q;
    head_time_d    = head_time_q;
    acc_d          = acc_q;
    refused_d      = refused_q;
    found_d        = found_q;
    started_d      = started_q;
    started_id_d   = started_id_q;
    assigned_d     = assigned_q;
    out_d          = out_q;
    out_vld_d      = out_vld_q && !out_o.ready;
    ram_we         = 1'b0;
    ram_waddr      = count_q[AW-1:0];
    ram_wdata      = {next_id_q, item_q.job_length};
    ram_re         = 1'b0;
    ram_raddr      = idx_q[AW-1:0];

    case (state_q)
      jqte_pkg::ST_IDLE: begin
        if (in_acc) begin
          item_d       = in_i.data;
          idx_d        = '0;
          acc_d        = '0;
          refused_d    = 1'b0;
          found_d      = 1'b0;
          started_d    = 1'b0;
          started_id_d = '0;
          assigned_d   = '0;
        end
      end
      // append at the tail, start at once on an empty queue
      jqte_pkg::ST_ADD: begin
        if (queue_full) begin
          refused_d = 1'b1;
        end else begin
          ram_we     = 1'b1;
          assigned_d = OW'(next_id_q);
          next_id_d  = next_id_q + ID_BITS'(1);
          count_d    = count_q + CNT_W'(1);
          if (queue_nil) begin
            head_started_d = 1'b1;
            head_time_d    = item_q.now_time;
            started_d      = 1'b1;
          end
        end
        idx_d = '0;
      end
      // walk from the head until the first matching id
      jqte_pkg::ST_SEARCH: begin
        ram_re   = can_issue;
        rd_vld_d = can_issue;
        if (can_issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (queue_nil) begin
          rd_vld_d = 1'b0;
          idx_d    = '0;
        end else if (rd_match) begin
          pos_d    = rd_idx_q;
          rd_vld_d = 1'b0;
          idx_d    = CNT_W'(rd_idx_q) + CNT_W'(1);
        end else if (last_rd) begin
          rd_vld_d = 1'b0;
          idx_d    = '0;
        end
      end
      // move every entry behind the match one place down
      jqte_pkg::ST_SHIFT: begin
        ram_re    = can_issue;
        rd_vld_d  = can_issue;
        if (can_issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        ram_we    = rd_vld_q;
        ram_waddr = rd_idx_q - AW'(1);
        ram_wdata = ram_rdata;
        if (last_rd) begin
          rd_vld_d = 1'b0;
        end
      end
      // drop the entry, start the new head if it is idle
      jqte_pkg::ST_DEL_DONE: begin
        found_d = 1'b1;
        count_d = count_q - CNT_W'(1);
        idx_d   = '0;
        if (count_q == CNT_W'(1)) begin
          head_started_d = 1'b0;
        end else if (!head_started_q || (pos_q == '0)) begin
          head_started_d = 1'b1;
          head_time_d    = item_q.now_time;
          started_d      = 1'b1;
        end
      end
      // total pass over all queued entries
      jqte_pkg::ST_SUM: begin
        ram_re   = can_issue;
        rd_vld_d = can_issue;
        if (can_issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          acc_d = acc_next;
          if (started_q && (rd_idx_q == '0)) begin
            started_id_d = OW'(rd_id);
          end
        end
        if (last_rd || queue_nil) begin
          rd_vld_d = 1'b0;
        end
      end
      // hand the result to the output register
      jqte_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_d           = 1'b1;
          out_d.assigned_id   = assigned_q;
          out_d.add_refused   = refused_q;
          out_d.delete_found  = found_q;
          out_d.started_valid = started_q;
          out_d.started_id    = started_id_q;
          out_d.total_time    = acc_q;
          out_d.queue_empty   = queue_nil;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= jqte_pkg::ST_IDLE;
      count_q        <= '0;
      next_id_q      <= '0;
      head_started_q <= 1'b0;
      head_time_q    <= '0;
      rd_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      next_id_q      <= next_id_d;
      head_started_q <= head_started_d;
      head_time_q    <= head_time_d;
      rd_vld_q       <= rd_vld_d;
      out_vld_q      <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    rd_idx_q     <= rd_idx_d;
    acc_q        <= acc_d;
    refused_q    <= refused_d;
    found_q      <= found_d;
    started_q    <= started_d;
    started_id_q <= started_id_d;
    assigned_q   <= assigned_d;
    out_q        <= out_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

>>> rtl/core/jqte_checker.sv
// ----------------------------------------------------------------------------
// jqte_checker
// Port-level checks of the job queue time estimator, bound to the top level.
// ----------------------------------------------------------------------------
module jqte_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input jqte_pkg::out_item_t out_data_i
);

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

  // a refused add changes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.add_refused |->
      !out_data_i.started_valid && !out_data_i.delete_found &&
      (out_data_i.assigned_id == '0))
    else $error("refused add reported activity");

  // an empty queue has no queue time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.queue_empty |-> (out_data_i.total_time == '0))
    else $error("empty queue with nonzero total");

  // a started job is in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.started_valid |-> !out_data_i.queue_empty)
    else $error("job started on empty queue");

endmodule

bind job_queue_time_estimator jqte_checker u_jqte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

>>> dv/job_queue_time_estimator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// job_queue_time_estimator_tb
// Self-checking bench for the job queue time estimator. A queued item driver
// and a result monitor run on the clock, a scoreboard model of the job queue
// predicts every result, and random stalls hit both channels.
// ----------------------------------------------------------------------------
module job_queue_time_estimator_tb;

  localparam int unsigned DEPTH      = jqte_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned ID_W       = jqte_pkg::OUT_ID_W;
  localparam int unsigned LEN_W      = jqte_pkg::LEN_W;
  localparam int unsigned TIME_W     = jqte_pkg::TIME_W;
  localparam int unsigned TOTAL_W    = jqte_pkg::TOTAL_W;
  localparam logic [1:0]  ACT_SPARE  = 2'd3;  // undefined code, acts as a query
  localparam int unsigned PRINT_CAP  = 50;

  typedef struct {
    jqte_pkg::in_item_t item;
    int unsigned        gap;
    bit                 drain_first;
    bit                 calm;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jqte_in_if  job_in ();
  jqte_out_if job_out ();

  job_queue_time_estimator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (job_in),
    .out_o  (job_out)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // pending items and expected results
  stim_t               stim_q[$];
  jqte_pkg::out_item_t expected_results[$];
  int unsigned         items_sent;
  int unsigned         results_seen;
  int unsigned         mismatches;

  // scoreboard copy of the job queue
  logic [ID_W-1:0]   jobs_id  [DEPTH];
  logic [LEN_W-1:0]  jobs_len [DEPTH];
  int unsigned       jobs_queued;
  logic [ID_W-1:0]   id_counter;
  logic [TIME_W-1:0] head_start;
  bit                head_running;

  // stimulus planning view of the queue ids
  logic [ID_W-1:0]   plan_ids[$];
  logic [ID_W-1:0]   plan_next;
  logic [TIME_W-1:0] plan_now;

  // handshake pacing
  int unsigned gap_left;
  bit          gap_taken;
  int unsigned rx_idle;
  bit          rx_calm;
  bit          rx_hold;

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, field, got, want));
  endtask

  // apply one item to the queue copy and return the result it causes
  function automatic jqte_pkg::out_item_t estimate_step(jqte_pkg::in_item_t it);
    jqte_pkg::out_item_t res;
    int                  hit;
    int                  k;
    logic [TOTAL_W:0]    sum;
    logic [TIME_W-1:0]   elapsed;
    logic [LEN_W-1:0]    part;
    res = '0;
    case (it.action)
      jqte_pkg::ACT_ADD: begin
        if (jobs_queued >= DEPTH) begin
          res.add_refused = 1'b1;
        end else begin
          res.assigned_id = id_counter;
          jobs_id[jobs_queued]  = id_counter;
          jobs_len[jobs_queued] = it.job_length;
          // an empty queue starts the new job at once
          if (jobs_queued == 0) begin
            head_running      = 1'b1;
            head_start        = it.now_time;
            res.started_valid = 1'b1;
            res.started_id    = id_counter;
          end
          id_counter++;
          jobs_queued++;
        end
      end
      jqte_pkg::ACT_DEL: begin
        hit = -1;
        for (k = 0; k < jobs_queued; k++)
          if (hit < 0 && jobs_id[k] == it.target_id) hit = k;
        if (hit >= 0) begin
          res.delete_found = 1'b1;
          if (hit == 0) head_running = 1'b0;
          for (k = hit; k + 1 < jobs_queued; k++) begin
            jobs_id[k]  = jobs_id[k+1];
            jobs_len[k] = jobs_len[k+1];
          end
          jobs_queued--;
          // a new head that is not running starts now
          if (jobs_queued == 0) begin
            head_running = 1'b0;
          end else if (!head_running) begin
            head_running      = 1'b1;
            head_start        = it.now_time;
            res.started_valid = 1'b1;
            res.started_id    = jobs_id[0];
          end
        end
      end
      default: ;
    endcase
    // total: waiting jobs by length, running head by max of elapsed and length
    sum = '0;
    for (k = 0; k < jobs_queued; k++) begin
      part = jobs_len[k];
      if (k == 0 && head_running) begin
        elapsed = it.now_time - head_start;
        if (elapsed >= jobs_len[0]) part = elapsed;
      end
      sum += part;
      if (sum > jqte_pkg::TOTAL_MAX) sum = jqte_pkg::TOTAL_MAX;
    end
    res.total_time  = sum[TOTAL_W-1:0];
    res.queue_empty = (jobs_queued == 0);
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [LEN_W-1:0] draw_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 8) return '1;
    if (r < 20) return $urandom;
    return $urandom_range(0, 300);
  endfunction

  // queue one item for the driver and track the ids it leaves behind
  task automatic plan_item(logic [1:0] act, logic [LEN_W-1:0] len,
                           logic [ID_W-1:0] target, int unsigned gap,
                           bit drain, bit calm);
    stim_t s;
    int    k;
    s.item.action     = act;
    s.item.job_length = len;
    s.item.target_id  = target;
    s.item.now_time   = plan_now;
    s.gap             = gap;
    s.drain_first     = drain;
    s.calm            = calm;
    stim_q.insert(stim_q.size(), s);
    if (act == jqte_pkg::ACT_ADD && plan_ids.size() < DEPTH) begin
      plan_ids.insert(plan_ids.size(), plan_next);
      plan_next++;
    end else if (act == jqte_pkg::ACT_DEL) begin
      for (k = 0; k < plan_ids.size(); k++)
        if (plan_ids[k] == target) begin
          plan_ids.delete(k);
          break;
        end
    end
  endtask

  // random segment, add_pct sets how hard the queue is pushed toward full
  task automatic plan_random(int unsigned n, int unsigned add_pct, bit calm);
    int unsigned     r;
    int unsigned     gap;
    logic [ID_W-1:0] target;
    for (int unsigned i = 0; i < n; i++) begin
      r   = $urandom_range(0, 99);
      gap = calm ? 0 : draw_gap();
      if ($urandom_range(0, 49) == 0) plan_now = $urandom;
      else plan_now += $urandom_range(0, 40);
      target = ID_W'($urandom);
      if (r < add_pct) begin
        plan_item(jqte_pkg::ACT_ADD, draw_length(), target, gap, i == 0, calm);
      end else if (r < add_pct + (100 - add_pct) * 6 / 10 && plan_ids.size() != 0) begin
        // delete a queued job, the head fairly often
        if ($urandom_range(0, 3) == 0) target = plan_ids[0];
        else target = plan_ids[$urandom_range(0, plan_ids.size() - 1)];
        plan_item(jqte_pkg::ACT_DEL, draw_length(), target, gap, i == 0, calm);
      end else begin
        case ($urandom_range(0, 2))
          0: plan_item(jqte_pkg::ACT_DEL, draw_length(), target, gap, i == 0, calm);
          1: plan_item(jqte_pkg::ACT_QUERY, draw_length(), target, gap, i == 0, calm);
          default: plan_item(ACT_SPARE, draw_length(), target, gap, i == 0, calm);
        endcase
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    stim_t nxt;
    bit    offer;
    if (!rst_ni) begin
      job_in.valid <= 1'b0;
      job_in.data  <= '0;
      gap_left     = 0;
      gap_taken    = 1'b0;
      jobs_queued  = 0;
      id_counter   = '0;
      head_start   = '0;
      head_running = 1'b0;
    end else begin
      if (job_in.valid && job_in.ready) begin
        expected_results.insert(expected_results.size(), estimate_step(job_in.data));
        items_sent++;
      end
      // present the next item once the current one is gone
      if (!job_in.valid || job_in.ready) begin
        offer = 1'b0;
        if (stim_q.size() != 0) begin
          if (!gap_taken) begin
            gap_left  = stim_q[0].gap;
            gap_taken = 1'b1;
          end
          if (gap_left != 0) begin
            gap_left--;
          end else if (!stim_q[0].drain_first || expected_results.size() == 0) begin
            nxt          = stim_q.pop_front();
            offer        = 1'b1;
            gap_taken    = 1'b0;
            job_in.data <= nxt.item;
            rx_calm     <= nxt.calm;
          end
        end
        job_in.valid <= offer;
      end
    end
  end

  // result ready pacing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_out.ready <= 1'b0;
      rx_idle       = 0;
    end else if (rx_hold) begin
      job_out.ready <= 1'b0;
    end else if (rx_idle != 0) begin
      rx_idle--;
      job_out.ready <= 1'b0;
    end else begin
      job_out.ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 25) rx_idle = draw_gap();
    end
  end

  // monitor
  always @(posedge clk_i) begin : watch_results
    jqte_pkg::out_item_t want;
    if (rst_ni && job_out.valid && job_out.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
        want = expected_results.pop_front();
        check_field("assigned_id", 64'(job_out.data.assigned_id), 64'(want.assigned_id));
        check_field("add_refused", 64'(job_out.data.add_refused), 64'(want.add_refused));
        check_field("delete_found", 64'(job_out.data.delete_found),
                    64'(want.delete_found));
        check_field("started_valid", 64'(job_out.data.started_valid),
                    64'(want.started_valid));
        check_field("started_id", 64'(job_out.data.started_id), 64'(want.started_id));
        check_field("total_time", 64'(job_out.data.total_time), 64'(want.total_time));
        check_field("queue_empty", 64'(job_out.data.queue_empty), 64'(want.queue_empty));
      end
      results_seen++;
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin : long_rx_stall
    rx_hold = 1'b0;
    wait (items_sent >= 150);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // watchdog
  initial begin
    #150ms;
    $display("status: fail");
    $finish;
  end

  // stimulus and end of test
  initial begin : main_flow
    plan_next = '0;

    // directed: empty queue, wrapped elapsed time, full queue, deletes
    plan_now = '0;
    plan_item(jqte_pkg::ACT_QUERY, '0, '0, 0, 1'b0, 1'b0);
    plan_item(jqte_pkg::ACT_DEL, '0, '0, 0, 1'b0, 1'b0);
    plan_item(ACT_SPARE, '1, '1, 0, 1'b0, 1'b0);
    plan_now = 32'hFFFF_FFF0;
    plan_item(jqte_pkg::ACT_ADD, 32'd5, '1, 0, 1'b0, 1'b0);
    plan_now = 32'h0000_0010;
    plan_item(jqte_pkg::ACT_QUERY, '0, '0, 0, 1'b0, 1'b0);
    plan_item(jqte_pkg::ACT_ADD, '1, '0, 0, 1'b0, 1'b0);
    plan_item(jqte_pkg::ACT_ADD, '0, '0, 0, 1'b0, 1'b0);
    for (int i = 0; i < 13; i++) begin
      plan_now += $urandom_range(0, 20);
      plan_item(jqte_pkg::ACT_ADD, $urandom_range(0, 500), ID_W'($urandom), 0,
                1'b0, 1'b0);
    end
    plan_item(jqte_pkg::ACT_ADD, 32'd7, '0, 0, 1'b0, 1'b0);
    plan_item(jqte_pkg::ACT_DEL, '0, 16'd7, 0, 1'b0, 1'b0);
    plan_item(jqte_pkg::ACT_DEL, '0, 16'd0, 0, 1'b0, 1'b0);
    plan_item(jqte_pkg::ACT_DEL, '0, 16'hFFFF, 0, 1'b0, 1'b0);
    plan_now = '1;
    plan_item(jqte_pkg::ACT_QUERY, '0, '0, 0, 1'b0, 1'b0);

    // random segments
    plan_random(300, 45, 1'b0);
    plan_random(200, 40, 1'b1);
    plan_random(250, 70, 1'b0);
    plan_random(250, 25, 1'b0);
    plan_random(300, 45, 1'b0);
    plan_random(300, 50, 1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || job_in.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> job_queue_time_estimator.f
rtl/core/jqte_pkg.sv
rtl/core/jqte_if.sv
rtl/core/jqte_ram.sv
rtl/core/job_queue_time_estimator.sv
rtl/core/jqte_checker.sv
dv/job_queue_time_estimator_tb.sv
